// File: src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/tgc_pkg.sv
package tgc_pkg;
   localparam int F_TDOWN = 0;
   localparam int F_DRAG  = 1;
   localparam int F_HOLD  = 2;
   localparam int F_CLICK = 3;
   localparam int F_MULTI = 4;
   localparam int F_REL   = 5;

   localparam logic [2:0] REG_MOVE   = 3'd0;
   localparam logic [2:0] REG_HOLD   = 3'd1;
   localparam logic [2:0] REG_CLICK  = 3'd2;
   localparam logic [2:0] REG_MULTI  = 3'd3;
   localparam logic [2:0] REG_SMOOTH = 3'd4;

   localparam logic [11:0] MOVE_RESET   = 12'd10;
   localparam logic [15:0] HOLD_RESET   = 16'd2000;
   localparam logic [15:0] CLICK_RESET  = 16'd500;
   localparam logic [15:0] MULTI_RESET  = 16'd500;
   localparam logic [7:0]  SMOOTH_RESET = 8'd51;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_INIT, ST_MS_RD, ST_MS_SQ, ST_MS_CHK, ST_NEW_WR,
      ST_LV_RD, ST_LV_SQ, ST_LV_UPD, ST_SW_RET, ST_SW_RD, ST_SW_CHK, ST_DONE
   } tgc_state_type;

   typedef struct packed {
      logic latch;
      logic init;
      logic rd_scan;
      logic scan_clr;
      logic scan_inc;
      logic sq;
      logic ms_chk;
      logic new_wr;
      logic lv_upd;
      logic retire;
      logic sw_chk;
      logic out_load;
   } tgc_cmd_type;

   typedef struct packed {
      logic op;
      logic in_range;
      logic new_path;
      logic scan_last;
      logic match;
      logic out_free;
   } tgc_status_type;
endpackage

// File: src/tgc_ctrl.sv
module tgc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tgc_pkg::tgc_status_type status,
   output tgc_pkg::tgc_cmd_type   cmd
);
   import tgc_pkg::*;

   tgc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.scan_clr = 1'b1;
            if (status.op) begin
               state_in = ST_SW_RET;
            end else if (!status.in_range) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = status.new_path ? ST_MS_RD : ST_LV_RD;
         end
         ST_MS_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = ST_MS_SQ;
         end
         ST_MS_SQ: begin
            cmd.rd_scan = 1'b1;
            cmd.sq      = 1'b1;
            state_in    = ST_MS_CHK;
         end
         ST_MS_CHK: begin
            cmd.rd_scan = 1'b1;
            cmd.ms_chk  = 1'b1;
            if (status.match || status.scan_last) begin
               state_in = ST_NEW_WR;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_MS_RD;
            end
         end
         ST_NEW_WR: begin
            cmd.new_wr = 1'b1;
            state_in   = ST_DONE;
         end
         ST_LV_RD: begin
            state_in = ST_LV_SQ;
         end
         ST_LV_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_LV_UPD;
         end
         ST_LV_UPD: begin
            cmd.lv_upd = 1'b1;
            state_in   = ST_DONE;
         end
         ST_SW_RET: begin
            cmd.retire = 1'b1;
            state_in   = ST_SW_RD;
         end
         ST_SW_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = ST_SW_CHK;
         end
         ST_SW_CHK: begin
            cmd.rd_scan = 1'b1;
            cmd.sw_chk  = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_SW_RD;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// File: src/tgc_dp.sv
module tgc_dp #(
   parameter int SLOTS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tgc_pkg::tgc_cmd_type   cmd,
   output tgc_pkg::tgc_status_type status,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic                   req_operation,
   input  logic [3:0]             req_slot,
   input  logic signed [15:0]     req_pos_x,
   input  logic signed [15:0]     req_pos_y,
   input  logic                   req_lifted,
   input  logic [31:0]            req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_out_slot,
   output logic [5:0]             rsp_gesture_flags,
   output logic [7:0]             rsp_click_count,
   output logic signed [15:0]     rsp_smooth_x,
   output logic signed [15:0]     rsp_smooth_y
);
   import tgc_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [11:0] move_ff;
   logic [15:0] hold_ff, click_ff, multi_ff;
   logic [7:0]  wgt_ff;
   logic [23:0] md2_ff;

   logic               op_ff, lifted_ff;
   logic [3:0]         slot_ff;
   logic signed [15:0] x_ff, y_ff;
   logic [31:0]        now_ff;
   logic [IW-1:0]      sidx, scan_ff, rd_addr;

   logic        active_ff [SLOTS];
   logic [5:0]  flags_ff  [SLOTS];
   logic [7:0]  clicks_ff [SLOTS];
   logic        hv_ff     [SLOTS];
   logic        hr_ff     [SLOTS];

   logic [31:0] hpos_mem_ff   [SLOTS];
   logic [31:0] htime_mem_ff  [SLOTS];
   logic [7:0]  hclk_mem_ff   [SLOTS];
   logic [31:0] smooth_mem_ff [SLOTS];

   logic [31:0] rd_pos_ff, rd_time_ff, rd_smooth_ff;
   logic [7:0]  rd_clk_ff;

   logic [32:0]        sqx_ff, sqy_ff;
   logic               elig_ff;
   logic signed [25:0] pox_ff, pnx_ff, poy_ff, pny_ff;
   logic [31:0]        el_ff;
   logic signed [15:0] res_x_ff, res_y_ff;

   logic signed [16:0] dx, dy;
   logic signed [33:0] dx2, dy2;
   logic [33:0]        d2;
   logic [8:0]         wnew;
   logic signed [26:0] accx, accy;
   logic [5:0]         f_cur, f_new;
   logic               drag_n, hold_n, click_n;
   logic [31:0]        sw_age;

   logic               rsp_valid_ff;
   logic [3:0]         out_slot_ff;
   logic [5:0]         out_flags_ff;
   logic [7:0]         out_clicks_ff;
   logic signed [15:0] out_x_ff, out_y_ff;

   assign sidx    = IW'(slot_ff);
   assign rd_addr = cmd.rd_scan ? scan_ff : sidx;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_ff  <= MOVE_RESET;
         hold_ff  <= HOLD_RESET;
         click_ff <= CLICK_RESET;
         multi_ff <= MULTI_RESET;
         wgt_ff   <= SMOOTH_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_MOVE:   move_ff  <= csr_wdata[11:0];
            REG_HOLD:   hold_ff  <= csr_wdata;
            REG_CLICK:  click_ff <= csr_wdata;
            REG_MULTI:  multi_ff <= csr_wdata;
            REG_SMOOTH: wgt_ff   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      md2_ff <= move_ff * move_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= req_operation;
         slot_ff   <= req_slot;
         x_ff      <= req_pos_x;
         y_ff      <= req_pos_y;
         lifted_ff <= req_lifted;
         now_ff    <= req_now_ms;
      end
      if (cmd.scan_clr) begin
         scan_ff <= '0;
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff    <= hpos_mem_ff[rd_addr];
      rd_time_ff   <= htime_mem_ff[rd_addr];
      rd_clk_ff    <= hclk_mem_ff[rd_addr];
      rd_smooth_ff <= smooth_mem_ff[rd_addr];
      if (cmd.new_wr) begin
         hpos_mem_ff[sidx]   <= {y_ff, x_ff};
         htime_mem_ff[sidx]  <= now_ff;
         hclk_mem_ff[sidx]   <= clicks_ff[sidx];
         smooth_mem_ff[sidx] <= {y_ff, x_ff};
      end else if (cmd.lv_upd) begin
         smooth_mem_ff[sidx] <= {accy[23:8], accx[23:8]};
      end
   end

   assign dx   = 17'(signed'(rd_pos_ff[15:0])) - 17'(x_ff);
   assign dy   = 17'(signed'(rd_pos_ff[31:16])) - 17'(y_ff);
   assign dx2  = dx * dx;
   assign dy2  = dy * dy;
   assign wnew = 9'd256 - {1'b0, wgt_ff};

   always_ff @(posedge clock) begin
      if (cmd.sq) begin
         sqx_ff  <= dx2[32:0];
         sqy_ff  <= dy2[32:0];
         elig_ff <= hv_ff[scan_ff] & hr_ff[scan_ff];
         el_ff   <= now_ff - rd_time_ff;
         pox_ff  <= 26'(signed'({1'b0, wgt_ff}) * signed'(rd_smooth_ff[15:0]));
         poy_ff  <= 26'(signed'({1'b0, wgt_ff}) * signed'(rd_smooth_ff[31:16]));
         pnx_ff  <= 26'(signed'({1'b0, wnew}) * x_ff);
         pny_ff  <= 26'(signed'({1'b0, wnew}) * y_ff);
      end
   end

   assign d2   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign accx = 27'(pox_ff) + 27'(pnx_ff) + 27'sd128;
   assign accy = 27'(poy_ff) + 27'(pny_ff) + 27'sd128;

   assign f_cur   = flags_ff[sidx];
   assign drag_n  = f_cur[F_DRAG] | (d2 >= {10'd0, md2_ff});
   assign hold_n  = f_cur[F_HOLD] | (!drag_n && el_ff >= {16'd0, hold_ff});
   assign click_n = f_cur[F_CLICK] |
                    (!drag_n && f_cur[F_REL] && el_ff <= {16'd0, click_ff});
   always_comb begin
      f_new          = f_cur;
      f_new[F_DRAG]  = drag_n;
      f_new[F_HOLD]  = hold_n;
      f_new[F_CLICK] = click_n;
      f_new[F_TDOWN] = 1'b0;
   end

   assign sw_age = now_ff - rd_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            active_ff[i] <= 1'b0;
            flags_ff[i]  <= '0;
            clicks_ff[i] <= 8'd1;
            hv_ff[i]     <= 1'b0;
            hr_ff[i]     <= 1'b0;
         end
      end else begin
         if (cmd.init) begin
            active_ff[sidx] <= 1'b1;
            if (!active_ff[sidx]) begin
               flags_ff[sidx]  <= {lifted_ff, 5'd0};
               clicks_ff[sidx] <= 8'd1;
            end else begin
               flags_ff[sidx][F_REL] <= flags_ff[sidx][F_REL] | lifted_ff;
            end
         end
         if (cmd.ms_chk && status.match) begin
            clicks_ff[sidx] <= (rd_clk_ff == 8'hFF) ? 8'hFF : rd_clk_ff + 8'd1;
            flags_ff[sidx][F_MULTI] <= 1'b1;
            hv_ff[scan_ff] <= 1'b0;
         end
         if (cmd.new_wr) begin
            flags_ff[sidx][F_TDOWN] <= 1'b1;
            hv_ff[sidx] <= 1'b1;
            hr_ff[sidx] <= flags_ff[sidx][F_REL];
         end
         if (cmd.lv_upd) begin
            flags_ff[sidx] <= f_new;
         end
         if (cmd.retire) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (active_ff[i] && flags_ff[i][F_REL]) begin
                  if (hv_ff[i]) begin
                     hr_ff[i] <= 1'b1;
                  end
                  active_ff[i] <= 1'b0;
                  flags_ff[i]  <= '0;
                  clicks_ff[i] <= 8'd1;
               end
            end
         end
         if (cmd.sw_chk && hv_ff[scan_ff] && hr_ff[scan_ff] &&
             sw_age > {16'd0, multi_ff}) begin
            hv_ff[scan_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.new_wr) begin
         res_x_ff <= x_ff;
         res_y_ff <= y_ff;
      end else if (cmd.lv_upd) begin
         res_x_ff <= accx[23:8];
         res_y_ff <= accy[23:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_slot_ff <= op_ff ? 4'd0 : slot_ff;
         if (!op_ff && status.in_range) begin
            out_flags_ff  <= flags_ff[sidx];
            out_clicks_ff <= clicks_ff[sidx];
            out_x_ff      <= res_x_ff;
            out_y_ff      <= res_y_ff;
         end else begin
            out_flags_ff  <= '0;
            out_clicks_ff <= '0;
            out_x_ff      <= '0;
            out_y_ff      <= '0;
         end
      end
   end

   assign status.op        = op_ff;
   assign status.in_range  = {3'd0, slot_ff} < 7'(SLOTS);
   assign status.new_path  = !hv_ff[sidx] || hr_ff[sidx];
   assign status.scan_last = scan_ff == IW'(SLOTS - 1);
   assign status.match     = elig_ff && d2 <= {10'd0, md2_ff};
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_slot      = out_slot_ff;
   assign rsp_gesture_flags = out_flags_ff;
   assign rsp_click_count   = out_clicks_ff;
   assign rsp_smooth_x      = out_x_ff;
   assign rsp_smooth_y      = out_y_ff;
endmodule

// File: src/touch_gesture_classifier.sv
// Touch gesture classifier.
// The request channel (req_*) carries one beat per operation: a point update for
// one slot, or a frame-start sweep of all slots. Every request beat produces
// exactly one response beat on the rsp_* channel with the slot's flags, click
// count and smoothed position. A sweep answers with all fields zero, and an update
// for a slot at or above SLOTS with all but the slot zero. Configuration registers
// are written through csr_write_en, csr_index and csr_wdata; the user must write
// them only while the block is idle, which the block does not enforce. A point
// update on a continuing touch reads its history entry and updates the smoothed
// position and flags; one that starts a new touch checks each history entry for a
// multi-tap match until a match or the last entry, then writes a new entry. A
// sweep retires released slots, then age-checks each history entry. One request
// is processed at a time; the next is accepted in the cycle after the response is
// loaded. The result sits in an output register; the next request is accepted
// while that response waits, and a stalled receiver holds the block only when a
// second result is ready. Synchronous reset clears all slots and history and
// restores the register defaults; no clearing pass is needed.
module touch_gesture_classifier #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [3:0]         req_slot,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic               req_lifted,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_out_slot,
   output logic [5:0]         rsp_gesture_flags,
   output logic [7:0]         rsp_click_count,
   output logic signed [15:0] rsp_smooth_x,
   output logic signed [15:0] rsp_smooth_y,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import tgc_pkg::*;

   tgc_cmd_type    cmd;
   tgc_status_type status;

   tgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tgc_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_operation     (req_operation),
      .req_slot          (req_slot),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_lifted        (req_lifted),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_slot      (rsp_out_slot),
      .rsp_gesture_flags (rsp_gesture_flags),
      .rsp_click_count   (rsp_click_count),
      .rsp_smooth_x      (rsp_smooth_x),
      .rsp_smooth_y      (rsp_smooth_y)
   );

`include "assert_macros.svh"

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))
   `ASSERT_IMPL(a_load_when_free, clock, reset, cmd.out_load, status.out_free)
endmodule
